// File: rtl/assert_macros.svh
// assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: rtl/krt_pkg.sv
`default_nettype none
package krt_pkg;
   localparam int ENTRIES = 64;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   localparam logic [2:0] CMD_DECLARE = 3'd0;
   localparam logic [2:0] CMD_WRITE   = 3'd1;
   localparam logic [2:0] CMD_PUBLISH = 3'd2;
   localparam logic [2:0] CMD_REMOTE  = 3'd3;
   localparam logic [2:0] CMD_READ    = 3'd4;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND    = 3'd1;
   localparam logic [2:0] ST_FULL         = 3'd2;
   localparam logic [2:0] ST_ZERO_KEY     = 3'd3;
   localparam logic [2:0] ST_MISMATCH     = 3'd4;
   localparam logic [2:0] ST_NOT_WRITABLE = 3'd5;
   localparam logic [2:0] ST_NOT_READABLE = 3'd6;
   localparam logic [2:0] ST_EVENT        = 3'd7;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] key_hash;
      logic [3:0]  value_type;
      logic [63:0] value_data;
      logic [31:0] time_a;
      logic [31:0] time_b;
      logic        faulty_in;
      logic [7:0]  unit_code;
      logic [7:0]  latency_code;
      logic [5:0]  class_bits;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  type_out;
      logic [63:0] value_out;
      logic [31:0] stamp_out;
      logic [31:0] age_out;
      logic [7:0]  unit_out;
      logic [7:0]  latency_out;
      logic [31:0] bound_out;
      logic [1:0]  policy_out;
      logic        has_data_out;
      logic        faulty_out;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request, start at home slot
      logic rd;        // issue read of probe slot
      logic step;      // advance probe slot
      logic commit;    // perform command on probe slot
      logic fail;      // finish with no slot found
      logic rsp_take;  // result consumed
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic zero_key;
      logic hit;
      logic empty;
      logic exhausted;
      logic rsp_busy;
   } sts_type;
endpackage
`default_nettype wire

// File: rtl/krt_ctrl.sv
`default_nettype none
module krt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire krt_pkg::sts_type sts,
   output krt_pkg::ctl_type      ctl,
   output logic                  idle
);
   import krt_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_WAIT  = 5'b00100,
      S_CHECK = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      unique case (state_ff)
         S_IDLE: if (start) begin
            ctl.load = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            if (sts.zero_key) begin
               if (!sts.rsp_busy) begin
                  ctl.fail = 1'b1;
                  state_in = S_OUT;
               end
            end else begin
               ctl.rd = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: state_in = S_CHECK;
         S_CHECK: begin
            if (sts.hit || sts.empty) begin
               if (!sts.rsp_busy) begin
                  ctl.commit = 1'b1;
                  state_in = S_OUT;
               end
            end else if (sts.exhausted) begin
               if (!sts.rsp_busy) begin
                  ctl.fail = 1'b1;
                  state_in = S_OUT;
               end
            end else begin
               ctl.step = 1'b1;
               state_in = S_READ;
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign idle = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   `ASSERT_IMPLIES(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `ASSERT_IMPLIES(a_excl, clock, reset, 1'b1, $onehot0({ctl.commit, ctl.fail, ctl.step}))
   `ASSERT_NEXT(a_rd_wait, clock, reset, ctl.rd, state_ff == S_WAIT)
endmodule
`default_nettype wire

// File: rtl/krt_datapath.sv
`default_nettype none
module krt_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire krt_pkg::req_type req,
   input  wire krt_pkg::ctl_type ctl,
   output krt_pkg::sts_type      sts,
   output logic                  rsp_valid,
   output krt_pkg::rsp_type      rsp
);
   import krt_pkg::*;
   `include "assert_macros.svh"

   logic [31:0] mem_key   [ENTRIES];
   logic [3:0]  mem_type  [ENTRIES];
   logic [63:0] mem_value [ENTRIES];
   logic [31:0] mem_stamp [ENTRIES];
   logic [31:0] mem_arr   [ENTRIES];
   logic [31:0] mem_bound [ENTRIES];
   logic [21:0] mem_attrs [ENTRIES];
   logic [1:0]  mem_flags [ENTRIES];

   // slots fill in arbitrary order, so keys are valid only where the per-slot
   // valid bit is set
   logic [ENTRIES-1:0] used_ff;

   req_type r_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [31:0] k_rd;
   logic [3:0]  t_rd;
   logic [63:0] v_rd;
   logic [31:0] s_rd, a_rd, b_rd;
   logic [21:0] at_rd;
   logic [1:0]  f_rd;
   logic        u_rd;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, res;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         r_ff <= req;
         idx_ff <= req.key_hash[IDX_W-1:0];
         cnt_ff <= '0;
      end else if (ctl.step) begin
         idx_ff <= idx_ff + 1'b1;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         k_rd <= mem_key[idx_ff];
         t_rd <= mem_type[idx_ff];
         v_rd <= mem_value[idx_ff];
         s_rd <= mem_stamp[idx_ff];
         a_rd <= mem_arr[idx_ff];
         b_rd <= mem_bound[idx_ff];
         at_rd <= mem_attrs[idx_ff];
         f_rd <= mem_flags[idx_ff];
         u_rd <= used_ff[idx_ff];
      end
   end

   assign sts.zero_key  = (r_ff.key_hash == 32'd0);
   assign sts.empty     = !u_rd;
   assign sts.hit       = u_rd && (k_rd == r_ff.key_hash);
   assign sts.exhausted = (cnt_ff == CNT_W'(ENTRIES - 1));
   assign sts.rsp_busy  = rsp_valid_ff && !ctl.rsp_take;

   logic mism, do_store, do_claim, do_attr;
   logic [5:0] c;
   assign c = at_rd[21:16];
   assign mism = (t_rd != 4'd0) && (t_rd != r_ff.value_type);

   always_comb begin
      res = '0;
      res.status = ST_NOT_FOUND;
      do_store = 1'b0;
      do_claim = 1'b0;
      do_attr = 1'b0;
      if (ctl.fail) begin
         if (r_ff.cmd == CMD_DECLARE)
            res.status = sts.zero_key ? ST_ZERO_KEY : ST_FULL;
      end else if (r_ff.cmd == CMD_DECLARE) begin
         if (sts.hit) begin
            do_attr = 1'b1;
            res.status = (t_rd != r_ff.value_type) ? ST_MISMATCH : ST_OK;
         end else begin
            do_claim = 1'b1;
            res.status = ST_OK;
         end
      end else if (sts.hit) begin
         unique case (r_ff.cmd)
            CMD_WRITE: begin
               if (!c[1]) res.status = ST_NOT_WRITABLE;
               else if (mism) res.status = ST_MISMATCH;
               else begin
                  res.status = ST_OK;
                  do_store = 1'b1;
               end
            end
            CMD_PUBLISH, CMD_REMOTE: begin
               if (mism) res.status = ST_MISMATCH;
               else begin
                  res.status = ST_OK;
                  do_store = 1'b1;
               end
            end
            CMD_READ: begin
               if (!c[0]) res.status = ST_NOT_READABLE;
               else if (c[3:2] == 2'd1) res.status = ST_EVENT;
               else begin
                  res.status = ST_OK;
                  res.type_out = t_rd;
                  res.value_out = v_rd;
                  res.stamp_out = s_rd;
                  res.age_out = f_rd[1] ? (r_ff.time_a - a_rd) : 32'd0;
                  res.unit_out = at_rd[7:0];
                  res.latency_out = at_rd[15:8];
                  res.bound_out = b_rd;
                  res.policy_out = c[5:4];
                  res.has_data_out = f_rd[1];
                  res.faulty_out = f_rd[0];
               end
            end
            default: res.status = ST_NOT_FOUND;
         endcase
      end
   end

   logic wr_en;
   assign wr_en = ctl.commit;

   always_ff @(posedge clock) begin
      if (wr_en && do_claim) begin
         mem_key[idx_ff] <= r_ff.key_hash;
         mem_type[idx_ff] <= r_ff.value_type;
         mem_value[idx_ff] <= '0;
         mem_stamp[idx_ff] <= '0;
         mem_arr[idx_ff] <= '0;
         mem_flags[idx_ff] <= '0;
      end
      if (wr_en && (do_claim || do_attr)) begin
         mem_bound[idx_ff] <= r_ff.time_a;
         mem_attrs[idx_ff] <= {r_ff.class_bits, r_ff.latency_code, r_ff.unit_code};
      end
      if (wr_en && do_store) begin
         mem_type[idx_ff] <= r_ff.value_type;
         mem_value[idx_ff] <= r_ff.value_data;
         mem_stamp[idx_ff] <= r_ff.time_a;
         mem_arr[idx_ff] <= (r_ff.cmd == CMD_REMOTE) ? r_ff.time_b : r_ff.time_a;
         mem_flags[idx_ff] <= {1'b1, (r_ff.cmd == CMD_REMOTE) && r_ff.faulty_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else if (wr_en && do_claim) used_ff[idx_ff] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (ctl.commit || ctl.fail) rsp_valid_ff <= 1'b1;
      else if (ctl.rsp_take) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (ctl.commit || ctl.fail) rsp_ff <= res;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   `ASSERT_IMPLIES(a_claim_free, clock, reset, wr_en && do_claim, !used_ff[idx_ff])
   `ASSERT_IMPLIES(a_no_overrun, clock, reset, ctl.commit || ctl.fail, !sts.rsp_busy)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !ctl.rsp_take, rsp_valid_ff)
endmodule
`default_nettype wire

// File: rtl/keyed_resource_table.sv
// request to result: the request is taken while idle, the home slot is read, the read data
// is registered, then compared; a miss probes a further slot; a zero key skips the read
// throughput: one request at a time; a result waits while the previous one is not taken
// probe loop: one table read per slot, read data registered before compare
// reset: synchronous active high; all slots free at once, no clearing pass
`default_nettype none
module keyed_resource_table (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // cmd, key_hash, value_type, value_data, time_a, time_b, faulty_in,
   // unit_code, latency_code, class_bits, zero fill
   input  wire logic [191:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status, type_out, value_out, stamp_out, age_out, unit_out, latency_out,
   // bound_out, policy_out, has_data_out, faulty_out, zero fill
   output logic [191:0]      rsp_tdata
);
   import krt_pkg::*;

   req_type req;
   rsp_type rsp;
   ctl_type ctl_c, ctl;
   sts_type sts;
   logic idle, rsp_valid;

   assign req.cmd          = req_tdata[2:0];
   assign req.key_hash     = req_tdata[34:3];
   assign req.value_type   = req_tdata[38:35];
   assign req.value_data   = req_tdata[102:39];
   assign req.time_a       = req_tdata[134:103];
   assign req.time_b       = req_tdata[166:135];
   assign req.faulty_in    = req_tdata[167];
   assign req.unit_code    = req_tdata[175:168];
   assign req.latency_code = req_tdata[183:176];
   assign req.class_bits   = req_tdata[189:184];

   assign req_tready = idle;

   always_comb begin
      ctl = ctl_c;
      ctl.rsp_take = rsp_valid && rsp_tready;
   end

   krt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(req_tvalid), .sts(sts), .ctl(ctl_c), .idle(idle)
   );

   krt_datapath u_dp (
      .clock(clock), .reset(reset), .req(req), .ctl(ctl), .sts(sts),
      .rsp_valid(rsp_valid), .rsp(rsp)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata = {5'b0, rsp.faulty_out, rsp.has_data_out, rsp.policy_out,
                       rsp.bound_out, rsp.latency_out, rsp.unit_out, rsp.age_out,
                       rsp.stamp_out, rsp.value_out, rsp.type_out, rsp.status};
endmodule
`default_nettype wire
